// ===== sv/scr_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the chunk reorder block.
package scr_pkg;

  localparam int STREAMS = 8;
  localparam int WINDOW  = 16;

  localparam int SIDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int WIDX_W = $clog2(WINDOW);
  localparam int ADDR_W = $clog2(STREAMS * WINDOW);
  localparam int DEPTH  = STREAMS * WINDOW;

  typedef enum logic [2:0] {
    K_OPEN     = 3'd0,
    K_CHUNK    = 3'd1,
    K_COMPLETE = 3'd2,
    K_ERROR    = 3'd3,
    K_CANCEL   = 3'd4
  } in_kind_t;

  typedef enum logic [1:0] {
    O_DELIVER  = 2'd0,
    O_COMPLETE = 2'd1,
    O_ERROR    = 2'd2,
    O_DROP     = 2'd3
  } out_kind_t;

  typedef enum logic [1:0] {
    H_NONE  = 2'd0,
    H_INPUT = 2'd1,
    H_MEM   = 2'd2
  } hsrc_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch;
    logic      init;
    logic      close;
    logic      set_final;
    logic      store;
    logic      rd;
    logic      load;
    out_kind_t okind;
    hsrc_t     hsrc;
    logic      last;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       slot_ok;
    logic [2:0] kind;
    logic       is_open;
    logic       unrel;
    logic       in_window;
    logic       beyond;
    logic       close_now;
    logic       final_hit;
    logic       entry_valid;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/scr_cmd_if.sv =====
// Request channel carrying one event into the reorder block.
interface scr_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  stream_slot;
  logic [31:0] sequence_req;
  logic [15:0] chunk_handle;
  logic        unreliable_mode;
  logic [31:0] error_num;

  modport source (output valid, kind, stream_slot, sequence_req, chunk_handle,
                  unreliable_mode, error_num, input ready);
  modport sink   (input valid, kind, stream_slot, sequence_req, chunk_handle,
                  unreliable_mode, error_num, output ready);
endinterface

// ===== sv/scr_res_if.sv =====
// Result channel carrying delivered chunks and stream notices.
interface scr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [2:0]  out_slot;
  logic [15:0] out_handle;
  logic [31:0] out_error_code;
  logic        out_last;

  modport source (output valid, out_kind, out_slot, out_handle, out_error_code,
                  out_last, input ready);
  modport sink   (input valid, out_kind, out_slot, out_handle, out_error_code,
                  out_last, output ready);
endinterface

// ===== sv/scr_cfg_if.sv =====
// Configuration write channel for the empty-stream final marker.
interface scr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] empty_final_marker;

  modport source (output valid, empty_final_marker, input ready);
  modport sink   (input valid, empty_final_marker, output ready);
endinterface

// ===== sv/scr_dp.sv =====
// Datapath: slot table, pending handle memory, configuration and output register.
module scr_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        kind,
  input  logic [2:0]        stream_slot,
  input  logic [31:0]       sequence_req,
  input  logic [15:0]       chunk_handle,
  input  logic              unreliable_mode,
  input  logic [31:0]       error_num,
  input  scr_pkg::ctl_t     ctl,
  output scr_pkg::stat_t    st,
  scr_cfg_if.sink           cfg,
  scr_res_if.source         res
);
  import scr_pkg::*;

  // Latched request.
  logic [2:0]  k_q;
  logic [2:0]  slot_q;
  logic [31:0] seq_q;
  logic [15:0] handle_q;
  logic        mode_q;
  logic [31:0] err_q;

  logic [31:0] marker;

  // Per-slot state.
  logic [STREAMS-1:0]             slot_open;
  logic [STREAMS-1:0]             slot_unrel;
  logic [STREAMS-1:0]             final_known;
  logic [31:0]                    next_exp   [STREAMS];
  logic [WIDX_W-1:0]              next_pos   [STREAMS];
  logic [31:0]                    final_val  [STREAMS];
  logic [STREAMS-1:0][WINDOW-1:0] pvalid;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;

  // Output register.
  logic        ov;
  logic [1:0]  o_kind;
  logic [2:0]  o_slot;
  logic [15:0] o_handle;
  logic [31:0] o_err;
  logic        o_last;

  logic [SIDX_W-1:0] sidx;
  logic [31:0]       cur_next;
  logic [WIDX_W-1:0] cur_pos;
  logic [31:0]       gap;
  logic              seq_ge;
  logic [WIDX_W:0]   idx_sum;
  logic [WIDX_W-1:0] store_idx;
  logic [WIDX_W-1:0] pos_next;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_free;

  assign sidx     = SIDX_W'(slot_q);
  assign cur_next = next_exp[sidx];
  assign cur_pos  = next_pos[sidx];
  assign gap      = seq_q - cur_next;
  assign seq_ge   = seq_q >= cur_next;

  // seq = next + gap with gap below the window, so the slot index is a
  // single add with one wrap correction.
  assign idx_sum   = (WIDX_W+1)'(cur_pos) + (WIDX_W+1)'(gap[WIDX_W-1:0]);
  assign store_idx = (idx_sum >= (WIDX_W+1)'(WINDOW)) ?
                     WIDX_W'(idx_sum - (WIDX_W+1)'(WINDOW)) : WIDX_W'(idx_sum);

  // A sequence wrap to zero also brings the window position back to zero.
  assign pos_next = ((cur_pos == WIDX_W'(WINDOW - 1)) || (cur_next == 32'hFFFF_FFFF)) ?
                    '0 : cur_pos + 1'b1;

  assign wr_addr = ADDR_W'(sidx * WINDOW) + ADDR_W'(store_idx);
  assign rd_addr = ADDR_W'(sidx * WINDOW) + ADDR_W'(cur_pos);

  assign out_free = !ov || res.ready;

  always_comb begin
    st.slot_ok     = 32'(slot_q) < STREAMS;
    st.kind        = k_q;
    st.is_open     = slot_open[sidx];
    st.unrel       = slot_unrel[sidx];
    st.in_window   = seq_ge && (gap < 32'(WINDOW));
    st.beyond      = seq_ge && (gap >= 32'(WINDOW));
    st.close_now   = slot_unrel[sidx] || (seq_q == marker) || (cur_next > seq_q);
    st.final_hit   = final_known[sidx] && (cur_next > final_val[sidx]);
    st.entry_valid = pvalid[sidx][cur_pos];
    st.out_free    = out_free;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= 32'hFFFF_FFFF;
    end else if (cfg.valid) begin
      marker <= cfg.empty_final_marker;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      k_q      <= kind;
      slot_q   <= stream_slot;
      seq_q    <= sequence_req;
      handle_q <= chunk_handle;
      mode_q   <= unreliable_mode;
      err_q    <= error_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open   <= '0;
      slot_unrel  <= '0;
      final_known <= '0;
      pvalid      <= '0;
      for (int i = 0; i < STREAMS; i++) begin
        next_exp[i] <= '0;
        next_pos[i] <= '0;
      end
    end else begin
      if (ctl.init || ctl.close) begin
        slot_open[sidx]   <= ctl.init;
        slot_unrel[sidx]  <= ctl.init && mode_q;
        final_known[sidx] <= 1'b0;
        next_exp[sidx]    <= '0;
        next_pos[sidx]    <= '0;
        pvalid[sidx]      <= '0;
      end
      if (ctl.set_final) begin
        final_known[sidx] <= 1'b1;
      end
      if (ctl.store) begin
        pvalid[sidx][store_idx] <= 1'b1;
      end
      if (ctl.rd) begin
        pvalid[sidx][cur_pos] <= 1'b0;
        next_exp[sidx]        <= cur_next + 32'd1;
        next_pos[sidx]        <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.set_final) begin
      final_val[sidx] <= seq_q;
    end
  end

  // Pending handle memory; a duplicate keeps the handle stored first.
  always_ff @(posedge clk) begin
    if (ctl.store && !pvalid[sidx][store_idx]) begin
      mem[wr_addr] <= handle_q;
    end
    if (ctl.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ctl.load) begin
      ov <= 1'b1;
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      o_kind <= ctl.okind;
      o_slot <= slot_q;
      o_last <= ctl.last;
      case (ctl.hsrc)
        H_INPUT: o_handle <= handle_q;
        H_MEM:   o_handle <= rdata;
        default: o_handle <= '0;
      endcase
      o_err <= (ctl.okind == O_ERROR) ? err_q : '0;
    end
  end

  assign res.valid          = ov;
  assign res.out_kind       = o_kind;
  assign res.out_slot       = o_slot;
  assign res.out_handle     = o_handle;
  assign res.out_error_code = o_err;
  assign res.out_last       = o_last;

`ifndef SYNTHESIS
  a_rd_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.rd |-> st.entry_valid)
    else $error("pending entry read while not valid");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> out_free)
    else $error("output register overwritten before it was taken");

  a_store_window: assert property (@(posedge clk) disable iff (rst)
    ctl.store |-> (st.is_open && st.in_window && !st.unrel))
    else $error("chunk stored outside an open reliable window");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.close |=> (pvalid[$past(sidx)] == '0) && !slot_open[$past(sidx)])
    else $error("closed slot still holds pending chunks");
`endif

endmodule

// ===== sv/scr_ctrl.sv =====
// Controller: sequences decode, store, in-order release and notices for one request.
module scr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           ready,
  input  scr_pkg::stat_t st,
  output scr_pkg::ctl_t  ctl
);
  import scr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_DLV,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.okind  = O_DELIVER;
    ctl.hsrc   = H_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        ctl.latch = valid;
        if (valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!st.slot_ok) begin
          state_next = S_IDLE;
        end else begin
          case (st.kind)
            K_OPEN: begin
              ctl.init   = 1'b1;
              state_next = S_IDLE;
            end
            K_CHUNK: begin
              if (!st.is_open) begin
                state_next = S_IDLE;
              end else if (st.unrel || st.beyond) begin
                if (st.out_free) begin
                  ctl.load   = 1'b1;
                  ctl.okind  = st.unrel ? O_DELIVER : O_DROP;
                  ctl.hsrc   = st.unrel ? H_INPUT : H_NONE;
                  ctl.last   = !st.final_hit;
                  state_next = S_FIN;
                end
              end else if (st.in_window) begin
                ctl.store  = 1'b1;
                state_next = S_RD;
              end else begin
                state_next = S_FIN;
              end
            end
            K_COMPLETE: begin
              if (!st.is_open) begin
                state_next = S_IDLE;
              end else if (!st.close_now) begin
                ctl.set_final = 1'b1;
                state_next    = S_IDLE;
              end else if (st.out_free) begin
                ctl.load   = 1'b1;
                ctl.okind  = O_COMPLETE;
                ctl.last   = 1'b1;
                ctl.close  = 1'b1;
                state_next = S_IDLE;
              end
            end
            K_ERROR, K_CANCEL: begin
              if (!st.is_open) begin
                state_next = S_IDLE;
              end else if (st.out_free) begin
                ctl.load   = 1'b1;
                ctl.okind  = (st.kind == K_ERROR) ? O_ERROR : O_COMPLETE;
                ctl.last   = 1'b1;
                ctl.close  = 1'b1;
                state_next = S_IDLE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        if (st.entry_valid) begin
          ctl.rd     = 1'b1;
          state_next = S_DLV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DLV: begin
        // The next entry is read in the same cycle the current one is loaded.
        if (st.out_free) begin
          ctl.load  = 1'b1;
          ctl.okind = O_DELIVER;
          ctl.hsrc  = H_MEM;
          ctl.last  = !st.entry_valid && !st.final_hit;
          if (st.entry_valid) begin
            ctl.rd = 1'b1;
          end else if (st.final_hit) begin
            state_next = S_FIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (!st.final_hit) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          ctl.load   = 1'b1;
          ctl.okind  = O_COMPLETE;
          ctl.last   = 1'b1;
          ctl.close  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/stream_chunk_reorder.sv =====
// Top level of the per-stream chunk reorder engine.
//
//   Channel   Direction  Payload
//   cmd       sink       kind, stream_slot, sequence_req, chunk_handle,
//                        unreliable_mode, error_num
//   res       source     out_kind, out_slot, out_handle, out_error_code, out_last
//   cfg       sink       empty_final_marker (always ready)
//
// One request at a time: accept, then decode. Opens, notices and ignored requests
// finish in decode; an unreliable, old or dropped chunk then passes the final check.
// A stored reliable chunk goes on to a read state, then a deliver state per released
// chunk (one registered read port on the handle memory); a completion is sent last.
// The slot table and pending valid bits clear at reset; no clearing pass.
// A stalled result channel holds the controller in place and nothing is lost.
module stream_chunk_reorder (
  input  logic      clk,
  input  logic      rst,
  scr_cmd_if.sink   cmd,
  scr_res_if.source res,
  scr_cfg_if.sink   cfg
);
  import scr_pkg::*;

  ctl_t  ctl;
  stat_t st;
  logic  ctrl_ready;

  assign cmd.ready = ctrl_ready;

  scr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (cmd.valid),
    .ready (ctrl_ready),
    .st    (st),
    .ctl   (ctl)
  );

  scr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .kind            (cmd.kind),
    .stream_slot     (cmd.stream_slot),
    .sequence_req    (cmd.sequence_req),
    .chunk_handle    (cmd.chunk_handle),
    .unreliable_mode (cmd.unreliable_mode),
    .error_num       (cmd.error_num),
    .ctl             (ctl),
    .st              (st),
    .cfg             (cfg),
    .res             (res)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the per-stream chunk reorder engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scr_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         DIR_N = 27;

  // How a directed row is checked.
  localparam logic [1:0] CHK_PREDICT = 2'd0;
  localparam logic [1:0] CHK_NONE    = 2'd1;
  localparam logic [1:0] CHK_ONE     = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SIDX_W-1:0] slot;
    logic [31:0]       seq;
    logic [15:0]       handle;
    logic              mode;
    logic [31:0]       err;
  } stream_req_t;

  typedef struct packed {
    out_kind_t         kind;
    logic [SIDX_W-1:0] slot;
    logic [15:0]       handle;
    logic [31:0]       err;
    logic              last;
  } notice_t;

  typedef struct packed {
    stream_req_t req;
    logic [1:0]  chk;
    out_kind_t   ek;
    logic [15:0] eh;
    logic [31:0] ee;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  scr_cmd_if cmd_ch ();
  scr_res_if res_ch ();
  scr_cfg_if cfg_ch ();

  stream_chunk_reorder u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #5ns clk = ~clk;

  // Shadow copy of the slot table and the register.
  logic [31:0]       marker;
  logic              st_open     [STREAMS];
  logic              st_unrel    [STREAMS];
  logic [31:0]       st_next     [STREAMS];
  logic              st_fin_known[STREAMS];
  logic [31:0]       st_fin      [STREAMS];
  logic              win_valid   [STREAMS][WINDOW];
  logic [15:0]       win_handle  [STREAMS][WINDOW];

  notice_t due_results[$];
  notice_t held;
  bit      held_ok = 1'b0;
  notice_t head;
  int      mismatches = 0;
  bit      calm = 1'b0;

  dir_row_t dir_rows [DIR_N] = '{
    '{'{K_CANCEL,   3'd0, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_OPEN,     3'd0, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h1,         16'hAAAA, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h1,         16'h5555, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'd18,        16'hBEEF, 1'b0, 32'h0}, CHK_ONE,     O_DROP,    16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0}, CHK_ONE,     O_DROP,    16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h3,         16'h1234, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h3,         16'h5678, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd0, 32'h2,         16'hFFFF, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_COMPLETE, 3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0}, CHK_ONE,     O_COMPLETE, 16'h0, 0},
    '{'{K_OPEN,     3'd7, 32'h0,         16'h0000, 1'b1, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0}, CHK_ONE,     O_DELIVER, 16'hFFFF, 0},
    '{'{K_COMPLETE, 3'd7, 32'h5,         16'h0000, 1'b0, 32'h0}, CHK_ONE,     O_COMPLETE, 16'h0, 0},
    '{'{K_OPEN,     3'd3, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_COMPLETE, 3'd3, 32'h2,         16'h0000, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd3, 32'h2,         16'h0002, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd3, 32'h1,         16'h0001, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd3, 32'h0,         16'h8000, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_OPEN,     3'd5, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_ERROR,    3'd5, 32'h0, 16'h0000, 1'b0, 32'hFFFF_FFFF}, CHK_ONE, O_ERROR, 16'h0, '1},
    '{'{K_OPEN,     3'd6, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_CHUNK,    3'd6, 32'h0,         16'h0007, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{K_COMPLETE, 3'd6, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_PREDICT, O_DELIVER, 16'h0, 0},
    '{'{KIND_SPARE, 3'd2, 32'h0,         16'h0000, 1'b1, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_OPEN,     3'd1, 32'h0,         16'h0000, 1'b1, 32'h0}, CHK_NONE,    O_DELIVER, 16'h0, 0},
    '{'{K_CANCEL,   3'd1, 32'h0,         16'h0000, 1'b0, 32'h0}, CHK_ONE,     O_COMPLETE, 16'h0, 0}
  };

  function automatic void clear_stream(input int s);
    st_open[s]      = 1'b0;
    st_unrel[s]     = 1'b0;
    st_next[s]      = '0;
    st_fin_known[s] = 1'b0;
    for (int w = 0; w < WINDOW; w++) win_valid[s][w] = 1'b0;
  endfunction

  // Results are held back by one so the last of a request can be marked.
  function automatic void owe(input out_kind_t k, input logic [SIDX_W-1:0] s,
                              input logic [15:0] h, input logic [31:0] e);
    if (held_ok) due_results.insert(due_results.size(), held);
    held    = '{k, s, h, e, 1'b0};
    held_ok = 1'b1;
  endfunction

  function automatic void apply_stream_event(input stream_req_t r);
    int                s;
    int                c;
    logic [31:0]       gap;
    logic [WIDX_W-1:0] idx;
    logic [WIDX_W-1:0] p;
    s = int'(r.slot);
    if (r.kind == K_OPEN) begin
      clear_stream(s);
      st_open[s]  = 1'b1;
      st_unrel[s] = r.mode;
      return;
    end
    if (r.kind > K_CANCEL || !st_open[s]) return;
    case (r.kind)
      K_CHUNK: begin
        if (st_unrel[s]) begin
          owe(O_DELIVER, r.slot, r.handle, '0);
        end else if (r.seq >= st_next[s]) begin
          gap = r.seq - st_next[s];
          if (gap >= 32'(WINDOW)) begin
            owe(O_DROP, r.slot, '0, '0);
          end else begin
            idx = r.seq[WIDX_W-1:0];
            if (!win_valid[s][idx]) begin
              win_valid[s][idx]  = 1'b1;
              win_handle[s][idx] = r.handle;
            end
            for (c = 0; c < WINDOW; c++) begin
              p = st_next[s][WIDX_W-1:0];
              if (!win_valid[s][p]) break;
              owe(O_DELIVER, r.slot, win_handle[s][p], '0);
              win_valid[s][p] = 1'b0;
              st_next[s]      = st_next[s] + 32'd1;
            end
          end
        end
        if (st_fin_known[s] && st_next[s] > st_fin[s]) begin
          owe(O_COMPLETE, r.slot, '0, '0);
          clear_stream(s);
        end
      end
      K_COMPLETE: begin
        if (st_unrel[s] || r.seq == marker || st_next[s] > r.seq) begin
          owe(O_COMPLETE, r.slot, '0, '0);
          clear_stream(s);
        end else begin
          st_fin_known[s] = 1'b1;
          st_fin[s]       = r.seq;
        end
      end
      K_ERROR: begin
        owe(O_ERROR, r.slot, '0, r.err);
        clear_stream(s);
      end
      default: begin
        owe(O_COMPLETE, r.slot, '0, '0);
        clear_stream(s);
      end
    endcase
    if (held_ok) begin
      held.last = 1'b1;
      due_results.insert(due_results.size(), held);
      held_ok = 1'b0;
    end
  endfunction

  // Mostly well-formed traffic on open streams, with stray and broken requests mixed in.
  function automatic stream_req_t draw_event();
    stream_req_t r;
    int          pick;
    logic [31:0] nx;
    r.kind   = K_CHUNK;
    r.slot   = SIDX_W'($urandom_range(0, STREAMS - 1));
    r.seq    = $urandom;
    r.handle = 16'($urandom);
    r.mode   = 1'($urandom_range(0, 1));
    r.err    = $urandom;
    pick     = $urandom_range(0, 99);
    nx       = st_next[r.slot];
    if (pick < 4) begin
      r.kind = 3'($urandom_range(K_CANCEL + 1, KIND_SPARE));
    end else if (pick < 10 || (!st_open[r.slot] && $urandom_range(0, 4) != 0)) begin
      r.kind = K_OPEN;
      r.mode = ($urandom_range(0, 3) == 0);
    end else if (pick < 72) begin
      case ($urandom_range(0, 9))
        0: r.seq = nx + WINDOW + (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
        1: r.seq = nx - 1 - $urandom_range(0, 3);
        2: ;
        default: r.seq = nx + $urandom_range(0, $urandom_range(0, WINDOW - 1));
      endcase
    end else if (pick < 82) begin
      r.kind = K_COMPLETE;
      case ($urandom_range(0, 5))
        0: r.seq = marker;
        1: r.seq = nx - 1;
        2: ;
        default: r.seq = nx + $urandom_range(0, 8);
      endcase
    end else if (pick < 91) begin
      r.kind = K_ERROR;
    end else begin
      r.kind = K_CANCEL;
    end
    return r;
  endfunction

  task automatic issue(input stream_req_t r, input logic [1:0] chk, input notice_t typed);
    int n0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.kind            <= r.kind;
    cmd_ch.stream_slot     <= r.slot;
    cmd_ch.sequence_req    <= r.seq;
    cmd_ch.chunk_handle    <= r.handle;
    cmd_ch.unreliable_mode <= r.mode;
    cmd_ch.error_num       <= r.err;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    n0 = due_results.size();
    apply_stream_event(r);
    if (chk != CHK_PREDICT) begin
      while (due_results.size() > n0) due_results.delete(due_results.size() - 1);
      if (chk == CHK_ONE) due_results.insert(due_results.size(), typed);
    end
  endtask

  // Requests that give no result may still be in flight when the queue runs dry.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [31:0] v);
    settle();
    cfg_ch.valid              <= 1'b1;
    cfg_ch.empty_final_marker <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    marker = v;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got kind %0d slot %0d handle %h",
                 $time, res_ch.out_kind, res_ch.out_slot, res_ch.out_handle);
      end else begin
        head = due_results[0];
        due_results.delete(0);
        check_field("out_kind", 32'(head.kind), 32'(res_ch.out_kind));
        check_field("out_slot", 32'(head.slot), 32'(res_ch.out_slot));
        check_field("out_handle", 32'(head.handle), 32'(res_ch.out_handle));
        check_field("out_error_code", head.err, res_ch.out_error_code);
        check_field("out_last", 32'(head.last), 32'(res_ch.out_last));
      end
    end
  end

  // Result side back-pressure.
  initial begin
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          i;
    int          ph;
    int          counted;
    stream_req_t r;
    rst                       = 1'b1;
    cmd_ch.valid              = 1'b0;
    cmd_ch.kind               = K_OPEN;
    cmd_ch.stream_slot        = '0;
    cmd_ch.sequence_req       = '0;
    cmd_ch.chunk_handle       = '0;
    cmd_ch.unreliable_mode    = 1'b0;
    cmd_ch.error_num          = '0;
    res_ch.ready              = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.empty_final_marker = '0;
    marker                    = 32'hFFFF_FFFF;
    for (i = 0; i < STREAMS; i++) clear_stream(i);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++)
      issue(dir_rows[i].req, dir_rows[i].chk,
            '{dir_rows[i].ek, dir_rows[i].req.slot, dir_rows[i].eh, dir_rows[i].ee, 1'b1});

    // Three marker settings: zero, a small value reachable by streams, all ones.
    counted = 0;
    for (ph = 0; ph < 3; ph++) begin
      if (ph == 0) write_marker(32'h0);
      else if (ph == 1) write_marker($urandom_range(1, 20));
      else write_marker(32'hFFFF_FFFF);
      while (counted < (ph + 1) * 25) begin
        r = draw_event();
        if (r.kind == K_OPEN || (r.kind <= K_CANCEL && st_open[r.slot])) counted++;
        calm = (counted >= 62);
        issue(r, CHK_PREDICT, '0);
      end
    end

    cmd_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/scr_pkg.sv
sv/scr_cmd_if.sv
sv/scr_res_if.sv
sv/scr_cfg_if.sv
sv/scr_dp.sv
sv/scr_ctrl.sv
sv/stream_chunk_reorder.sv
sim/tb.sv
